// ===== rtl/mns_pkg.sv =====
// Shared types, widths and helpers for the melody note sequencer.
`default_nettype none

package mns_pkg;

    localparam int ADDR_W         = 10;
    localparam int FREQ_W         = 15;
    localparam int DUR_W          = 16;
    localparam int ELAPSED_W      = 17;
    localparam int NOTE_DEPTH_DEF = 1024;

    typedef enum logic [1:0] {
        KIND_TICK  = 2'd0,
        KIND_PLAY  = 2'd1,
        KIND_STOP  = 2'd2,
        KIND_WRITE = 2'd3
    } t_kind;

    typedef struct packed {
        logic [FREQ_W-1:0] freq;
        logic [DUR_W-1:0]  dur;
    } t_entry;

    // An entry with zero frequency and zero duration ends a melody.
    function automatic logic is_end(input t_entry e);
        return (e.freq == '0) && (e.dur == '0);
    endfunction

endpackage

`default_nettype wire

// ===== rtl/mns_note_mem.sv =====
// Note memory: one write port, two registered read ports with same-edge write forwarding.
`default_nettype none

module mns_note_mem #(
    parameter int  NOTE_DEPTH = mns_pkg::NOTE_DEPTH_DEF,
    localparam int AW         = $clog2(NOTE_DEPTH)
) (
    input  wire logic            i_clk,
    input  wire logic            i_rst_n,
    input  wire logic            i_wr_en,
    input  wire logic [AW-1:0]   i_wr_addr,
    input  wire mns_pkg::t_entry i_wr_data,
    input  wire logic [AW-1:0]   i_rd_a_addr,
    output mns_pkg::t_entry      o_rd_a_data,
    input  wire logic [AW-1:0]   i_rd_b_addr,
    output mns_pkg::t_entry      o_rd_b_data
);

    mns_pkg::t_entry r_mem [NOTE_DEPTH];
    mns_pkg::t_entry r_rd_a;
    mns_pkg::t_entry r_rd_b;
    logic [AW-1:0]   r_a_addr;
    logic [AW-1:0]   r_b_addr;
    logic            r_wr_en;
    logic [AW-1:0]   r_wr_addr;
    mns_pkg::t_entry r_wr_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        r_rd_a    <= r_mem[i_rd_a_addr];
        r_rd_b    <= r_mem[i_rd_b_addr];
        r_a_addr  <= i_rd_a_addr;
        r_b_addr  <= i_rd_b_addr;
        r_wr_addr <= i_wr_addr;
        r_wr_data <= i_wr_data;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_en <= 1'b0;
        end else begin
            r_wr_en <= i_wr_en;
        end
    end

    // Forward a write that landed on the same edge as the read.
    assign o_rd_a_data = (r_wr_en && (r_wr_addr == r_a_addr)) ? r_wr_data : r_rd_a;
    assign o_rd_b_data = (r_wr_en && (r_wr_addr == r_b_addr)) ? r_wr_data : r_rd_b;

endmodule

`default_nettype wire

// ===== rtl/mns_core.sv =====
// Play state and per-beat update logic of the melody note sequencer.
`default_nettype none

module mns_core #(
    parameter int  NOTE_DEPTH = mns_pkg::NOTE_DEPTH_DEF,
    localparam int AW         = $clog2(NOTE_DEPTH)
) (
    input  wire logic                         i_clk,
    input  wire logic                         i_rst_n,
    input  wire logic                         i_fire,
    input  wire mns_pkg::t_kind               i_kind,
    input  wire logic [AW-1:0]                i_addr,
    input  wire mns_pkg::t_entry              i_note,
    input  wire logic                         i_repeat_req,
    input  wire mns_pkg::t_entry              i_rd_next,
    input  wire mns_pkg::t_entry              i_rd_item,
    output logic [AW-1:0]                     o_next_addr,
    output logic                              o_wr_en,
    output logic [AW-1:0]                     o_wr_addr,
    output mns_pkg::t_entry                   o_wr_data,
    output logic [mns_pkg::FREQ_W-1:0]        o_tone_freq,
    output logic                              o_playing
);

    localparam int ELW = mns_pkg::ELAPSED_W;

    logic [AW-1:0]              r_cur,      n_cur;
    logic [AW-1:0]              r_start,    n_start;
    logic                       r_repeat,   n_repeat;
    logic                       r_active,   n_active;
    logic [ELW-1:0]             r_elapsed,  n_elapsed;
    logic [mns_pkg::FREQ_W-1:0] r_freq,     n_freq;
    logic [mns_pkg::DUR_W-1:0]  r_cur_dur,  n_cur_dur;
    mns_pkg::t_entry            r_start_ent, n_start_ent;

    always_comb begin
        logic            enter_go;
        logic [AW-1:0]   enter_addr;
        mns_pkg::t_entry enter_ent;
        logic [ELW-1:0]  el_inc;

        n_cur       = r_cur;
        n_start     = r_start;
        n_repeat    = r_repeat;
        n_active    = r_active;
        n_elapsed   = r_elapsed;
        n_freq      = r_freq;
        n_cur_dur   = r_cur_dur;
        n_start_ent = r_start_ent;
        enter_go    = 1'b0;
        enter_addr  = i_addr;
        enter_ent   = i_rd_item;
        el_inc      = (r_elapsed == '1) ? r_elapsed : ELW'(r_elapsed + 1'b1);
        o_wr_en     = 1'b0;

        if (i_fire) begin
            case (i_kind)
                mns_pkg::KIND_TICK: begin
                    if (r_active) begin
                        n_elapsed = el_inc;
                        if (el_inc > ELW'(r_cur_dur)) begin
                            enter_go   = 1'b1;
                            enter_addr = AW'(r_cur + 1'b1);
                            enter_ent  = i_rd_next;
                        end
                    end
                end
                mns_pkg::KIND_PLAY: begin
                    n_start     = i_addr;
                    n_start_ent = i_rd_item;
                    n_repeat    = i_repeat_req;
                    enter_go    = 1'b1;
                end
                mns_pkg::KIND_STOP: begin
                    n_active = 1'b0;
                    n_repeat = 1'b0;
                    n_freq   = '0;
                end
                default: begin
                    o_wr_en = 1'b1;
                    // keep cached copies of the current and start entries coherent
                    if (i_addr == r_cur) begin
                        n_cur_dur = i_note.dur;
                    end
                    if (i_addr == r_start) begin
                        n_start_ent = i_note;
                    end
                end
            endcase
        end

        if (enter_go) begin
            n_cur     = enter_addr;
            n_elapsed = '0;
            n_active  = 1'b1;
            n_freq    = enter_ent.freq;
            n_cur_dur = enter_ent.dur;
            if (mns_pkg::is_end(enter_ent)) begin
                // restart at the start entry while repeat is set, or drop out of play
                if (n_repeat && !mns_pkg::is_end(n_start_ent)) begin
                    n_cur     = n_start;
                    n_freq    = n_start_ent.freq;
                    n_cur_dur = n_start_ent.dur;
                end else begin
                    n_active = 1'b0;
                    n_freq   = '0;
                end
            end
        end
    end

    assign o_wr_addr   = i_addr;
    assign o_wr_data   = i_note;
    assign o_next_addr = AW'(n_cur + 1'b1);
    assign o_tone_freq = n_active ? n_freq : '0;
    assign o_playing   = n_active;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cur       <= '0;
            r_start     <= '0;
            r_repeat    <= 1'b0;
            r_active    <= 1'b0;
            r_elapsed   <= '0;
            r_freq      <= '0;
            r_cur_dur   <= '0;
            r_start_ent <= '0;
        end else begin
            r_cur       <= n_cur;
            r_start     <= n_start;
            r_repeat    <= n_repeat;
            r_active    <= n_active;
            r_elapsed   <= n_elapsed;
            r_freq      <= n_freq;
            r_cur_dur   <= n_cur_dur;
            r_start_ent <= n_start_ent;
        end
    end

endmodule

`default_nettype wire

// ===== rtl/melody_note_sequencer_top.sv =====
// Top level of the melody note sequencer: input beat register, core, note memory, result register.
//
// Input channel (i_valid / o_stall): each beat is a tick of one millisecond, a play
// request (start address and repeat flag), a stop, or a note entry write. A beat is
// taken at a rising edge with i_valid high and o_stall low.
// Result channel (o_valid / i_stall): exactly one result beat per input beat, in order,
// carrying the tone to sound now (0 when silent or on a rest) and the playing flag.
// Throughput: one beat per cycle, sustained while the receiver does not stall. A beat
// taken at one edge sits in the input register while the note memory's registered read
// ports fetch its entry and the entry after the current note, and its result is loaded
// into the output register when the beat fires. Those two read ports carry the rate: the
// current note's duration and the start entry are kept in registers, so no beat needs
// a second memory read.
// Addresses wrap modulo NOTE_DEPTH, which must be a power of two.
// Reset (i_rst_n low at a clock edge) empties both registers and leaves the block silent
// and not playing; the note memory keeps its contents and holds garbage until written.
// When the receiver stalls, the result beat holds and one more beat may wait in the
// input register; after that o_stall rises until the result is taken.
`default_nettype none

module melody_note_sequencer_top #(
    parameter int NOTE_DEPTH = mns_pkg::NOTE_DEPTH_DEF
) (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          i_valid,
    output logic                               o_stall,
    input  wire logic [1:0]                    i_kind,
    input  wire logic [mns_pkg::ADDR_W-1:0]    i_address,
    input  wire logic [mns_pkg::FREQ_W-1:0]    i_note_freq,
    input  wire logic [mns_pkg::DUR_W-1:0]     i_note_duration,
    input  wire logic                          i_repeat_req,
    output logic                               o_valid,
    input  wire logic                          i_stall,
    output logic [mns_pkg::FREQ_W-1:0]         o_tone_freq,
    output logic                               o_playing
);

    localparam int AW = $clog2(NOTE_DEPTH);

    // input beat register
    logic                  r_in_valid;
    mns_pkg::t_kind        r_in_kind;
    logic [AW-1:0]         r_in_addr;
    mns_pkg::t_entry       r_in_note;
    logic                  r_in_rep;

    // result register
    logic                       r_out_valid;
    logic [mns_pkg::FREQ_W-1:0] r_out_tone;
    logic                       r_out_playing;

    logic                       accept;
    logic                       fire;
    logic                       out_free;
    logic [AW-1:0]              in_addr_wrap;
    logic [AW-1:0]              rd_b_addr;
    logic [AW-1:0]              next_addr;
    logic                       wr_en;
    logic [AW-1:0]              wr_addr;
    mns_pkg::t_entry            wr_data;
    mns_pkg::t_entry            rd_next;
    mns_pkg::t_entry            rd_item;
    logic [mns_pkg::FREQ_W-1:0] core_tone;
    logic                       core_playing;

    // Advance the waiting beat whenever the result register is empty or being drained.
    assign out_free     = !r_out_valid || !i_stall;
    assign fire         = r_in_valid && out_free;
    assign o_stall      = r_in_valid && !out_free;
    assign accept       = i_valid && !o_stall;
    assign in_addr_wrap = AW'(i_address);
    // Fetch the new beat's entry on acceptance, otherwise refresh the held beat's entry.
    assign rd_b_addr    = accept ? in_addr_wrap : r_in_addr;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (accept) begin
            r_in_valid <= 1'b1;
        end else if (fire) begin
            r_in_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_in_kind      <= mns_pkg::t_kind'(i_kind);
            r_in_addr      <= in_addr_wrap;
            r_in_note.freq <= i_note_freq;
            r_in_note.dur  <= i_note_duration;
            r_in_rep       <= i_repeat_req;
        end
    end

    mns_core #(
        .NOTE_DEPTH (NOTE_DEPTH)
    ) u_core (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_fire       (fire),
        .i_kind       (r_in_kind),
        .i_addr       (r_in_addr),
        .i_note       (r_in_note),
        .i_repeat_req (r_in_rep),
        .i_rd_next    (rd_next),
        .i_rd_item    (rd_item),
        .o_next_addr  (next_addr),
        .o_wr_en      (wr_en),
        .o_wr_addr    (wr_addr),
        .o_wr_data    (wr_data),
        .o_tone_freq  (core_tone),
        .o_playing    (core_playing)
    );

    mns_note_mem #(
        .NOTE_DEPTH (NOTE_DEPTH)
    ) u_mem (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_wr_en     (wr_en),
        .i_wr_addr   (wr_addr),
        .i_wr_data   (wr_data),
        .i_rd_a_addr (next_addr),
        .o_rd_a_data (rd_next),
        .i_rd_b_addr (rd_b_addr),
        .o_rd_b_data (rd_item)
    );

    // Hold the result until taken; load a fresh one whenever a beat fires.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (fire) begin
            r_out_valid <= 1'b1;
        end else if (!i_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (fire) begin
            r_out_tone    <= core_tone;
            r_out_playing <= core_playing;
        end
    end

    assign o_valid     = r_out_valid;
    assign o_tone_freq = r_out_tone;
    assign o_playing   = r_out_playing;

    // A silent block never reports a tone.
    a_silent_when_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && !o_playing) |-> (o_tone_freq == '0))
        else $error("tone reported while not playing");

    // Every fired beat lands in the result register.
    a_fire_gives_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        fire |=> o_valid)
        else $error("fired beat produced no result");

    // Backpressure only while a beat is waiting.
    a_stall_needs_beat: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_stall |-> (r_in_valid && r_out_valid))
        else $error("input stalled with nothing waiting");

endmodule

`default_nettype wire
